// ===== rtl/core/glcr_pkg.sv =====
// Package for the GF(2^8) Lagrange coefficient recovery block.
// Holds sizes, controller commands and the field multiply function.
package glcr_pkg;
  localparam int MaxPoints = 16;
  localparam int IdxW = 4;
  localparam int CntW = 5;

  localparam logic [3:0] CMD_IDLE    = 4'd0;
  localparam logic [3:0] CMD_LOAD    = 4'd1;
  localparam logic [3:0] CMD_CLR_ACC = 4'd2;
  localparam logic [3:0] CMD_INIT_I  = 4'd3;
  localparam logic [3:0] CMD_BASIS   = 4'd4;
  localparam logic [3:0] CMD_DENOM   = 4'd5;
  localparam logic [3:0] CMD_INV     = 4'd6;
  localparam logic [3:0] CMD_SCALE   = 4'd7;
  localparam logic [3:0] CMD_ACC     = 4'd8;
  localparam logic [3:0] CMD_EMIT    = 4'd9;

  typedef struct packed {
    logic [3:0]      op;
    logic [IdxW-1:0] i;
    logic [IdxW-1:0] j;
    logic [IdxW-1:0] l;
    logic [CntW-1:0] deg;
  } cmd_t;

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'd0;
    x = a;
    for (int n = 0; n < 8; n++) begin
      if (b[n]) p = p ^ x;
      x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction
endpackage

// ===== rtl/core/glcr_datapath.sv =====
// Datapath: point stores, basis polynomial, accumulators, one shared multiplier.
// Depends on glcr_pkg.
module glcr_datapath (
  input  logic              clk,
  input  glcr_pkg::cmd_t    cmd,
  input  logic [7:0]        x_code,
  input  logic [7:0]        y_value,
  input  logic [3:0]        load_idx,
  output logic [7:0]        coefficient
);
  import glcr_pkg::*;

  logic [7:0] x_store [MaxPoints];
  logic [7:0] y_store [MaxPoints];
  logic [7:0] basis [MaxPoints+1];
  logic [7:0] acc [MaxPoints];
  logic [7:0] denom;
  logic [7:0] inv;
  logic [7:0] base;
  logic [7:0] scale;
  logic [7:0] xi;
  logic [7:0] xj;
  logic [7:0] mul_a;
  logic [7:0] mul_b;
  logic [7:0] mul_p;
  logic [CntW-1:0] lp;
  logic [CntW-1:0] lq;

  assign xi = x_store[cmd.i];
  assign xj = x_store[cmd.j];
  assign lp = cmd.deg + 5'd1 - {1'b0, cmd.l};
  assign lq = lp - 5'd1;

  always_comb begin
    mul_a = 8'd0;
    mul_b = 8'd0;
    case (cmd.op)
      CMD_BASIS: begin mul_a = basis[lp]; mul_b = xj; end
      CMD_DENOM: begin mul_a = denom; mul_b = xi ^ xj; end
      CMD_INV: begin mul_a = cmd.l[0] ? base : inv; mul_b = base; end
      CMD_SCALE: begin mul_a = y_store[cmd.i]; mul_b = inv; end
      CMD_ACC: begin mul_a = basis[{1'b0, cmd.l} + 5'd1]; mul_b = scale; end
      default: begin mul_a = 8'd0; mul_b = 8'd0; end
    endcase
  end
  assign mul_p = gf_mul(mul_a, mul_b);

  always_ff @(posedge clk) begin
    case (cmd.op)
      CMD_LOAD: begin
        x_store[load_idx] <= x_code;
        y_store[load_idx] <= y_value;
      end
      CMD_CLR_ACC: for (int n = 0; n < MaxPoints; n++) acc[n] <= 8'd0;
      CMD_INIT_I: begin
        for (int n = 0; n <= MaxPoints; n++) basis[n] <= (n == 1) ? 8'd1 : 8'd0;
        denom <= 8'd1;
      end
      CMD_BASIS: basis[lp] <= basis[lq] ^ mul_p;
      CMD_DENOM: denom <= mul_p;
      CMD_INV: begin
        // l zero: load base from denom; l odd: square base; other even l: multiply result (exp 254 = bits 1..7)
        if (cmd.l == 4'd0) begin
          base <= denom; inv <= 8'd1;
        end else if (cmd.l[0]) base <= mul_p;
        else inv <= mul_p;
      end
      CMD_SCALE: scale <= (denom == 8'd0) ? 8'd0 : mul_p;
      CMD_ACC: acc[cmd.l] <= acc[cmd.l] ^ mul_p;
      default: ;
    endcase
  end

  assign coefficient = acc[cmd.l];
endmodule

// ===== rtl/core/glcr_ctrl.sv =====
// Controller: load counting, compute sequencing and coefficient output.
// Depends on glcr_pkg.
module glcr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [4:0]     cfg_data,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [3:0]     coeff_index,
  output logic           last,
  output logic [3:0]     load_idx,
  output glcr_pkg::cmd_t cmd
);
  import glcr_pkg::*;

  localparam logic [2:0] S_LOAD = 3'd0, S_CLR = 3'd1, S_INIT = 3'd2, S_BAS = 3'd3,
    S_DEN = 3'd4, S_INV = 3'd5, S_SCL = 3'd6, S_ACC = 3'd7;

  logic [2:0] state;
  logic       emit;
  logic [4:0] kreg;
  logic [4:0] loaded;
  logic [3:0] i, j, l;
  logic [4:0] deg;
  logic [3:0] km1;
  logic       skip;

  assign km1 = kreg[3:0] - 4'd1;
  assign load_idx = loaded[3:0];
  assign in_ready = (state == S_LOAD) && !emit;
  assign out_valid = emit;
  assign coeff_index = l;
  assign last = (l == km1);
  assign skip = (j == i);

  always_comb begin
    cmd.op = CMD_IDLE;
    cmd.i = i; cmd.j = j; cmd.l = l; cmd.deg = deg;
    if (emit) cmd.op = CMD_EMIT;
    else case (state)
      S_LOAD: cmd.op = (in_valid) ? CMD_LOAD : CMD_IDLE;
      S_CLR: cmd.op = CMD_CLR_ACC;
      S_INIT: cmd.op = CMD_INIT_I;
      S_BAS: cmd.op = skip ? CMD_IDLE : CMD_BASIS;
      S_DEN: cmd.op = CMD_DENOM;
      S_INV: cmd.op = CMD_INV;
      S_SCL: cmd.op = CMD_SCALE;
      default: cmd.op = CMD_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD; emit <= 1'b0; kreg <= 5'd1; loaded <= 5'd0;
      i <= 4'd0; j <= 4'd0; l <= 4'd0; deg <= 5'd0;
    end else if (cfg_we) begin
      kreg <= (cfg_data == 5'd0) ? 5'd1 : (cfg_data > 5'd16 ? 5'd16 : cfg_data);
      loaded <= 5'd0;
    end else if (emit) begin
      if (out_ready) begin
        l <= l + 4'd1;
        if (l == km1) begin emit <= 1'b0; state <= S_LOAD; end
      end
    end else begin
      case (state)
        S_LOAD: if (in_valid) begin
          if (loaded + 5'd1 == kreg) begin
            loaded <= 5'd0; state <= S_CLR; i <= 4'd0;
          end else loaded <= loaded + 5'd1;
        end
        S_CLR: state <= S_INIT;
        S_INIT: begin j <= 4'd0; l <= 4'd0; deg <= 5'd1; state <= S_BAS; end
        S_BAS: begin
          // one cell of the basis update per cycle, from top down
          if (skip) begin
            if (j == km1) state <= S_INV;
            else j <= j + 4'd1;
          end else if (l == deg[3:0]) begin
            l <= 4'd0; deg <= deg + 5'd1; state <= S_DEN;
          end else l <= l + 4'd1;
        end
        S_DEN: begin
          if (j == km1) begin state <= S_INV; l <= 4'd0; end
          else begin j <= j + 4'd1; state <= S_BAS; end
        end
        S_INV: begin
          if (l == 4'd14) begin l <= 4'd0; state <= S_SCL; end
          else l <= l + 4'd1;
        end
        S_SCL: begin l <= 4'd0; state <= S_ACC; end
        default: begin
          if (l == km1) begin
            l <= 4'd0;
            if (i == km1) emit <= 1'b1;
            else begin i <= i + 4'd1; state <= S_INIT; end
          end else l <= l + 4'd1;
        end
      endcase
    end
  end
endmodule

// ===== rtl/core/gf256_lagrange_coeff_recover.sv =====
// Top level of the GF(2^8) Lagrange coefficient recovery block.
// Instantiates glcr_ctrl and glcr_datapath; depends on glcr_pkg.
//
// Usage: write point_count (cfg_we/cfg_data, clamped to 1..16) while idle;
// this restarts loading. Send K points on in_valid/in_ready (x_code,
// y_value). in_ready stays high until the K-th is taken. After the K-th
// the block computes with its single shared field multiplier, then sends K
// words on out_valid/out_ready: coefficient, coeff_index from 0 upward,
// last on the final word. One word per cycle when the receiver is ready;
// a stall holds the word. No new point is taken during compute or output.
// Reset (rst, synchronous) sets K to 1 and empties the point count.
module gf256_lagrange_coeff_recover (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [4:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] x_code,
  input  logic [7:0] y_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] coefficient,
  output logic [3:0] coeff_index,
  output logic       last
);
  import glcr_pkg::*;

  cmd_t       cmd;
  logic [3:0] load_idx;

  glcr_ctrl u_ctrl (
    .clk, .rst, .cfg_we, .cfg_data, .in_valid, .in_ready, .out_valid,
    .out_ready, .coeff_index, .last, .load_idx, .cmd
  );

  glcr_datapath u_dp (
    .clk, .cmd, .x_code, .y_value, .load_idx, .coefficient
  );
endmodule

// ===== verif/tb_gf256_lagrange_coeff_recover.sv =====
`timescale 1ns / 1ps
// Testbench for gf256_lagrange_coeff_recover: loads point sets, predicts the
// interpolated coefficients with its own GF(2^8) math, checks every output word.
// Depends on glcr_pkg (sizes) and the RTL top level.
module tb_gf256_lagrange_coeff_recover;
  import glcr_pkg::*;

  typedef struct packed {
    logic [7:0] coef;
    logic [3:0] idx;
    logic       lst;
  } coeff_word_t;

  typedef struct {
    bit         is_cfg;
    logic [4:0] cfg;
    logic [7:0] x;
    logic [7:0] y;
    bit         has_exp;
    logic [7:0] exp_coef;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [4:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] x_code = '0;
  logic [7:0] y_value = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] coefficient;
  logic [3:0] coeff_index;
  logic       last;

  logic [4:0] count_reg;
  logic [7:0] xs [MaxPoints];
  logic [7:0] ys [MaxPoints];
  int         loaded;
  coeff_word_t coeff_q [$];
  logic [7:0] pinned_q [$];
  int         errors;
  bit         stim_done;

  always #10 clk = ~clk;

  gf256_lagrange_coeff_recover u_top (.*);

  function automatic logic [7:0] fmul(logic [7:0] a, logic [7:0] b);
    logic [8:0] x;
    logic [7:0] p;
    p = 8'd0;
    x = {1'b0, a};
    for (int n = 0; n < 8; n++) begin
      if (b[n]) p ^= x[7:0];
      x = x << 1;
      if (x[8]) x ^= 9'h11b;
    end
    return p;
  endfunction

  function automatic logic [7:0] fdiv(logic [7:0] n, logic [7:0] q);
    logic [7:0] r;
    logic [7:0] b;
    r = 8'd1;
    b = q;
    if (n == 8'd0 || q == 8'd0) return 8'd0;
    for (int e = 254; e != 0; e >>= 1) begin
      if (e & 1) r = fmul(r, b);
      b = fmul(b, b);
    end
    return fmul(n, r);
  endfunction

  function automatic int points_needed();
    if (count_reg < 1) return 1;
    if (count_reg > MaxPoints) return MaxPoints;
    return int'(count_reg);
  endfunction

  task automatic interpolate(int k);
    logic [7:0] acc [MaxPoints];
    logic [7:0] bp [MaxPoints+1];
    logic [7:0] den;
    logic [7:0] sc;
    int deg;
    for (int l = 0; l < MaxPoints; l++) acc[l] = 8'd0;
    for (int i = 0; i < k; i++) begin
      for (int l = 0; l <= MaxPoints; l++) bp[l] = 8'd0;
      bp[1] = 8'd1;
      den = 8'd1;
      deg = 0;
      for (int j = 0; j < k; j++) begin
        if (j == i) continue;
        den = fmul(den, xs[i] ^ xs[j]);
        deg++;
        for (int l = deg + 1; l >= 1; l--)
          if (l <= MaxPoints) bp[l] = bp[l-1] ^ fmul(bp[l], xs[j]);
      end
      sc = fdiv(ys[i], den);
      for (int l = 0; l < k; l++) acc[l] ^= fmul(bp[l+1], sc);
    end
    for (int l = 0; l < k; l++)
      coeff_q.insert(coeff_q.size(), {acc[l], 4'(l), l + 1 == k});
  endtask

  task automatic accept_point(logic [7:0] x, logic [7:0] y);
    int k;
    k = points_needed();
    if (loaded >= k) loaded = 0;
    xs[loaded] = x;
    ys[loaded] = y;
    loaded++;
    if (loaded == k) begin
      interpolate(k);
      loaded = 0;
    end
  endtask

  task automatic report(string what, logic [7:0] got, logic [7:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  task automatic idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return;
    in_valid <= 1'b0;
    repeat (r < 92 ? $urandom_range(1, 3) : $urandom_range(10, 60)) @(posedge clk);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (coeff_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_count(logic [4:0] v);
    wait_drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    count_reg = v;
    loaded = 0;
  endtask

  // valid stays up after acceptance; the caller drops it before any gap
  task automatic send_point(logic [7:0] x, logic [7:0] y);
    in_valid <= 1'b1;
    x_code <= x;
    y_value <= y;
    do @(posedge clk); while (!in_ready);
    accept_point(x, y);
  endtask

  // output side: random stalls, check each accepted word
  always @(posedge clk) begin
    coeff_word_t w;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (coeff_q.size() == 0) begin
          report("unexpected word", coefficient, 8'd0);
        end else begin
          w = coeff_q.pop_front();
          if (pinned_q.size() != 0 && w.idx == 4'd0) begin
            if (w.coef != pinned_q[0]) report("pinned coeff", w.coef, pinned_q[0]);
            void'(pinned_q.pop_front());
          end
          if (coefficient !== w.coef) report("coefficient", coefficient, w.coef);
          if (coeff_index !== w.idx)
            report("coeff_index", {4'd0, coeff_index}, {4'd0, w.idx});
          if (last !== w.lst) report("last", {7'd0, last}, {7'd0, w.lst});
        end
      end
      out_ready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 19) == 0);
    end
  end

  stim_row_t rows [$];

  task automatic add_row(stim_row_t r);
    rows.insert(rows.size(), r);
  endtask

  task automatic add_pt(logic [7:0] x, logic [7:0] y);
    add_row('{1'b0, 5'd0, x, y, 1'b0, 8'd0});
  endtask

  initial begin
    int k;
    logic [7:0] xv;
    errors = 0;
    loaded = 0;
    count_reg = 5'd1;
    stim_done = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // K=1 after reset: constant term equals y
    add_row('{1'b0, 5'd0, 8'h00, 8'h00, 1'b1, 8'h00});
    add_row('{1'b0, 5'd0, 8'hff, 8'hff, 1'b1, 8'hff});
    add_row('{1'b0, 5'd0, 8'h5a, 8'ha5, 1'b1, 8'ha5});
    // count 0 acts as 1
    add_row('{1'b1, 5'd0, 8'h00, 8'h00, 1'b0, 8'h00});
    add_row('{1'b0, 5'd0, 8'h12, 8'h34, 1'b1, 8'h34});
    // K=2, duplicate x: both points add nothing
    add_row('{1'b1, 5'd2, 8'h00, 8'h00, 1'b0, 8'h00});
    add_pt(8'h07, 8'h11);
    add_pt(8'h07, 8'h22);
    add_pt(8'h01, 8'hff);
    add_pt(8'hff, 8'h01);
    // count above max acts as 16
    add_row('{1'b1, 5'd31, 8'h00, 8'h00, 1'b0, 8'h00});
    for (int i = 0; i < 16; i++) add_pt(8'(i * 17), 8'($urandom));
    // rewrite mid-load restarts
    add_row('{1'b1, 5'd3, 8'h00, 8'h00, 1'b0, 8'h00});
    add_pt(8'h10, 8'h20);
    add_row('{1'b1, 5'd3, 8'h00, 8'h00, 1'b0, 8'h00});
    foreach (rows[n]) begin
      if (rows[n].is_cfg) begin
        write_count(rows[n].cfg);
      end else begin
        if (rows[n].has_exp) pinned_q.insert(pinned_q.size(), rows[n].exp_coef);
        send_point(rows[n].x, rows[n].y);
      end
    end

    for (int n = 0; n < 205; ) begin
      if ($urandom_range(0, 9) == 0 || loaded == 0 && $urandom_range(0, 5) == 0) begin
        k = $urandom_range(0, 9) == 0 ? 16 : $urandom_range(1, 6);
        if ($urandom_range(0, 19) == 0) k = $urandom_range(0, 31);
        write_count(5'(k));
      end
      if ($urandom_range(0, 29) == 0) wait_drain();
      xv = $urandom_range(0, 7) == 0 && loaded > 0 ? xs[0] : 8'($urandom);
      send_point(xv, 8'($urandom));
      n++;
      idle_gap();
    end
    wait_drain();
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    if (errors == 0 && coeff_q.size() == 0 && pinned_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #400ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/core/glcr_pkg.sv
rtl/core/glcr_datapath.sv
rtl/core/glcr_ctrl.sv
rtl/core/gf256_lagrange_coeff_recover.sv
verif/tb_gf256_lagrange_coeff_recover.sv
